// ----- rtl/rspi_pkg.sv -----
// ----------------------------------------------------------------------------
// rspi_pkg
// Shared types, constants and tables of the Reeds-Shepp pose interpolator.
// ----------------------------------------------------------------------------
package rspi_pkg;

  localparam int SEG_COUNT    = 5;
  localparam int CORDIC_STEPS = 24;
  localparam int ANG_W        = 28;  // Q.16 heading, unwrapped
  localparam int TRIG_W       = 34;  // Q.30 sine, cosine and CORDIC datapath
  localparam int DIV_W        = 42;  // angle scaled to Q.30
  localparam int QBITS        = 11;  // quadrant count bits of the reduction

  localparam logic [DIV_W-1:0]         HALF_PI_Q30  = DIV_W'(64'd1686629713);
  localparam logic signed [TRIG_W-1:0] HALF_PI_S    = TRIG_W'(64'sd1686629713);
  localparam logic signed [TRIG_W-1:0] QUARTER_PI_S = TRIG_W'(64'sd843314856);
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN  = TRIG_W'(64'sd652032874);
  // just below 2^60 / HALF_PI_Q30, so the quotient estimate is never high
  localparam logic [29:0]              RECIP_HALF_PI = 30'd683565274;

  typedef enum logic [1:0] {
    SEG_NONE     = 2'd0,
    SEG_LEFT     = 2'd1,
    SEG_STRAIGHT = 2'd2,
    SEG_RIGHT    = 2'd3
  } seg_type_t;

  typedef struct packed {
    logic                    start;
    logic signed [ANG_W-1:0] angle;
  } sc_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] sin;
    logic signed [TRIG_W-1:0] cos;
  } sc_resp_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:    v = 30'd843314857;
      5'd1:    v = 30'd497837829;
      5'd2:    v = 30'd263043836;
      5'd3:    v = 30'd133525159;
      5'd4:    v = 30'd67021687;
      5'd5:    v = 30'd33543516;
      5'd6:    v = 30'd16775851;
      5'd7:    v = 30'd8388437;
      5'd8:    v = 30'd4194283;
      5'd9:    v = 30'd2097149;
      5'd10:   v = 30'd1048576;
      5'd11:   v = 30'd524288;
      5'd12:   v = 30'd262144;
      5'd13:   v = 30'd131072;
      5'd14:   v = 30'd65536;
      5'd15:   v = 30'd32768;
      5'd16:   v = 30'd16384;
      5'd17:   v = 30'd8192;
      5'd18:   v = 30'd4096;
      5'd19:   v = 30'd2048;
      5'd20:   v = 30'd1024;
      5'd21:   v = 30'd512;
      5'd22:   v = 30'd256;
      5'd23:   v = 30'd128;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/rspi_sincos.sv -----
// ----------------------------------------------------------------------------
// rspi_sincos
// Sine and cosine of a Q.16 angle: quadrant reduction by a reciprocal multiply
// with one correction step, 24 CORDIC rotations, then quadrant rotation.
// Results in Q.30.
// ----------------------------------------------------------------------------
module rspi_sincos (
  input  logic             clk,
  input  logic             rst,
  input  rspi_pkg::sc_req_t  req,
  output rspi_pkg::sc_resp_t resp
);
  import rspi_pkg::*;

  typedef enum logic [2:0] {
    SC_IDLE, SC_MUL, SC_REM, SC_FIX, SC_RED, SC_ROT, SC_FIN
  } sc_state_t;

  sc_state_t                state;
  logic [ANG_W-1:0]         amag;
  logic [DIV_W-1:0]         mag;
  logic                     neg;
  logic [QBITS-1:0]         qm;
  logic [1:0]               q;
  logic signed [TRIG_W-1:0] x, y, z;
  logic [4:0]               i;

  logic [56:0]              recip_p;
  logic signed [TRIG_W-1:0] rem_s, rr;
  logic [1:0]               qq;
  logic signed [TRIG_W-1:0] xs, ys, at;

  always_comb begin
    recip_p  = 57'(amag) * 57'(RECIP_HALF_PI);
    rem_s    = $signed({2'b00, mag[31:0]});
    rr       = neg ? -rem_s : rem_s;
    qq       = neg ? 2'(-qm[1:0]) : qm[1:0];
    if (rr > QUARTER_PI_S) begin
      rr = rr - HALF_PI_S;
      qq = qq + 2'd1;
    end else if (rr < -QUARTER_PI_S) begin
      rr = rr + HALF_PI_S;
      qq = qq - 2'd1;
    end
    xs = x >>> i;
    ys = y >>> i;
    at = $signed({4'b0000, atan_q30(i)});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SC_IDLE;
      resp.done <= 1'b0;
    end else begin
      resp.done <= 1'b0;
      unique case (state)
        SC_IDLE: begin
          if (req.start) begin
            amag  <= req.angle[ANG_W-1] ? ANG_W'(-req.angle) : ANG_W'(req.angle);
            neg   <= req.angle[ANG_W-1];
            state <= SC_MUL;
          end
        end
        SC_MUL: begin
          // quotient estimate, equal to the true one or one below
          qm    <= recip_p[56:46];
          state <= SC_REM;
        end
        SC_REM: begin
          mag   <= {amag, 14'b0} - qm * HALF_PI_Q30;
          state <= SC_FIX;
        end
        SC_FIX: begin
          if (mag >= HALF_PI_Q30) begin
            mag <= mag - HALF_PI_Q30;
            qm  <= qm + QBITS'(1);
          end
          state <= SC_RED;
        end
        SC_RED: begin
          z     <= rr;
          q     <= qq;
          x     <= CORDIC_GAIN;
          y     <= '0;
          i     <= '0;
          state <= SC_ROT;
        end
        SC_ROT: begin
          if (z >= 0) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end
          if (i == 5'(CORDIC_STEPS - 1)) state <= SC_FIN;
          else i <= i + 5'd1;
        end
        SC_FIN: begin
          case (q)
            2'd0: begin resp.sin <= y;  resp.cos <= x;  end
            2'd1: begin resp.sin <= x;  resp.cos <= -y; end
            2'd2: begin resp.sin <= -y; resp.cos <= -x; end
            default: begin resp.sin <= -x; resp.cos <= y; end
          endcase
          resp.done <= 1'b1;
          state     <= SC_IDLE;
        end
        default: state <= SC_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/reeds_shepp_path_pose_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// reeds_shepp_path_pose_interpolator_unit
// Pose after a query distance along a five-segment Reeds-Shepp path.
// ----------------------------------------------------------------------------
// One item at a time. An item is set up and scaled; each segment reached by
// the distance takes a pass through ST_SEG, plus for a straight one
// sine/cosine evaluation and the multiply states ST_MC, ST_MS and ST_MSA, or
// for an arc two evaluations. Each evaluation in the shared CORDIC unit runs
// a reciprocal quadrant reduction and 24 rotations. Scaling waits while a
// previous result is still held. in_stall is high from acceptance until the
// result is registered; the result register holds it while out_stall is high.
// turning_radius is written through cfg_valid/cfg_data, always ready.
module reeds_shepp_path_pose_interpolator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [18:0] start_yaw,
  input  logic signed [24:0] query_distance,
  input  logic [9:0]         segment_types,
  input  logic signed [23:0] seg_len_0,
  input  logic signed [23:0] seg_len_1,
  input  logic signed [23:0] seg_len_2,
  input  logic signed [23:0] seg_len_3,
  input  logic signed [23:0] seg_len_4,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [23:0] out_yaw
);
  import rspi_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TOTAL, ST_SEG, ST_WAIT0, ST_WAIT1,
    ST_MC, ST_MS, ST_MSA, ST_SCX, ST_SCY, ST_SCYA
  } state_t;

  state_t                   state;
  logic [23:0]              radius;
  logic signed [31:0]       sx, sy;
  logic signed [24:0]       qd;
  logic [9:0]               types;
  logic signed [23:0]       len_r [SEG_COUNT];
  logic [2:0]               idx;
  logic signed [26:0]       seg;
  logic signed [ANG_W-1:0]  yaw;
  logic signed [23:0]       v_r;
  seg_type_t                t_r;
  logic signed [43:0]       ox, oy;
  logic signed [TRIG_W-1:0] s0, c0;
  logic signed [59:0]       mul_p;
  logic signed [40:0]       px;
  sc_req_t                  sc_req;
  sc_resp_t                 sc_resp;

  logic [26:0]              total;
  logic signed [26:0]       seg_clamp;
  logic [2:0]               idx_c;
  logic signed [26:0]       len_c, v_c, seg_n;
  logic signed [34:0]       mul_a;
  logic signed [24:0]       mul_b;
  logic signed [59:0]       p16, p20;
  logic signed [43:0]       ox10, oy10;
  logic signed [40:0]       py_c;
  logic signed [ANG_W-1:0]  yaw_arc;

  rspi_sincos u_sincos (
    .clk  (clk),
    .rst  (rst),
    .req  (sc_req),
    .resp (sc_resp)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);

  always_comb begin
    total = '0;
    for (int j = 0; j < SEG_COUNT; j++) begin
      total = total + 27'(len_r[j] < 0 ? -$signed({len_r[j][23], len_r[j]})
                                       : $signed({len_r[j][23], len_r[j]}));
    end
    if (qd < 0) seg_clamp = '0;
    else if (27'(qd) > $signed(total)) seg_clamp = $signed(total);
    else seg_clamp = 27'(qd);

    idx_c = (idx < 3'(SEG_COUNT)) ? idx : 3'd0;
    len_c = 27'(len_r[idx_c]);
    if (len_c < 0) begin
      v_c   = (-seg > len_c) ? -seg : len_c;
      seg_n = seg + v_c;
    end else begin
      v_c   = (seg < len_c) ? seg : len_c;
      seg_n = seg - v_c;
    end

    ox10 = ox + 44'sd512;
    oy10 = oy + 44'sd512;
    unique case (state)
      ST_MC:   begin mul_a = 35'(c0);          mul_b = 25'(v_r); end
      ST_MS:   begin mul_a = 35'(s0);          mul_b = 25'(v_r); end
      ST_SCX:  begin
        mul_a = 35'($signed(ox10[43:10]));
        mul_b = $signed({1'b0, radius});
      end
      ST_SCY:  begin
        mul_a = 35'($signed(oy10[43:10]));
        mul_b = $signed({1'b0, radius});
      end
      default: begin mul_a = '0;               mul_b = '0; end
    endcase
    p16  = mul_p + 60'sd32768;
    p20  = mul_p + 60'sd524288;
    py_c = 41'(sy) + 41'($signed(p20[59:20]));
    yaw_arc = (t_r == SEG_LEFT) ? yaw + ANG_W'(v_r) : yaw - ANG_W'(v_r);
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    if (rst) begin
      state        <= ST_IDLE;
      radius       <= 24'd327680;
      out_valid    <= 1'b0;
      sc_req.start <= 1'b0;
    end else begin
      sc_req.start <= 1'b0;
      if (cfg_valid && cfg_ready) radius <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            sx       <= start_x;
            sy       <= start_y;
            yaw      <= ANG_W'(start_yaw);
            qd       <= query_distance;
            types    <= segment_types;
            len_r[0] <= seg_len_0;
            len_r[1] <= seg_len_1;
            len_r[2] <= seg_len_2;
            len_r[3] <= seg_len_3;
            len_r[4] <= seg_len_4;
            state    <= ST_TOTAL;
          end
        end
        ST_TOTAL: begin
          seg   <= seg_clamp;
          idx   <= '0;
          ox    <= '0;
          oy    <= '0;
          state <= ST_SEG;
        end
        ST_SEG: begin
          if (idx == 3'(SEG_COUNT) || seg == 0) begin
            state <= ST_SCX;
          end else begin
            v_r <= 24'(v_c);
            seg <= seg_n;
            idx <= idx + 3'd1;
            t_r <= seg_type_t'(types[2*idx_c +: 2]);
            if (seg_type_t'(types[2*idx_c +: 2]) != SEG_NONE) begin
              sc_req.start <= 1'b1;
              sc_req.angle <= yaw;
              state        <= ST_WAIT0;
            end
          end
        end
        ST_WAIT0: begin
          if (sc_resp.done) begin
            s0 <= sc_resp.sin;
            c0 <= sc_resp.cos;
            if (t_r == SEG_STRAIGHT) begin
              state <= ST_MC;
            end else begin
              sc_req.start <= 1'b1;
              sc_req.angle <= yaw_arc;
              state        <= ST_WAIT1;
            end
          end
        end
        ST_WAIT1: begin
          if (sc_resp.done) begin
            if (t_r == SEG_LEFT) begin
              ox <= ox + 44'(sc_resp.sin - s0);
              oy <= oy + 44'(c0 - sc_resp.cos);
            end else begin
              ox <= ox + 44'(s0 - sc_resp.sin);
              oy <= oy + 44'(sc_resp.cos - c0);
            end
            yaw   <= yaw_arc;
            state <= ST_SEG;
          end
        end
        ST_MC:  state <= ST_MS;
        ST_MS: begin
          ox    <= ox + p16[59:16];
          state <= ST_MSA;
        end
        ST_MSA: begin
          oy    <= oy + p16[59:16];
          state <= ST_SEG;
        end
        ST_SCX: begin
          // hold here until the result register is free
          if (!out_valid || !out_stall) state <= ST_SCY;
        end
        ST_SCY: begin
          px    <= 41'(sx) + 41'($signed(p20[59:20]));
          state <= ST_SCYA;
        end
        ST_SCYA: begin
          // y product is in mul_p now; saturate both coordinates and the heading
          if (px > 41'sd2147483647) out_x <= 32'sh7FFFFFFF;
          else if (px < -41'sd2147483648) out_x <= 32'sh80000000;
          else out_x <= 32'(px);
          if (py_c > 41'sd2147483647) out_y <= 32'sh7FFFFFFF;
          else if (py_c < -41'sd2147483648) out_y <= 32'sh80000000;
          else out_y <= 32'(py_c);
          if (yaw > 28'sd8388607) out_yaw <= 24'sh7FFFFF;
          else if (yaw < -28'sd8388608) out_yaw <= 24'sh800000;
          else out_yaw <= 24'(yaw);
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
